>>> rtl/frk_pkg.sv
// ----------------------------------------------------------------------------
// frk_pkg
// Shared constants and types for the frequency rank key builder.
// ----------------------------------------------------------------------------
package frk_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int NUM_LETTERS = 26;
  localparam int INDEX_WIDTH = $clog2(NUM_LETTERS);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [INDEX_WIDTH-1:0] index_t;
  typedef logic [7:0]             byte_t;

  typedef enum logic [1:0] {
    ACT_REFERENCE = 2'd0,
    ACT_CIPHER    = 2'd1,
    ACT_FINISH    = 2'd2,
    ACT_UNUSED    = 2'd3
  } action_t;

  localparam byte_t CHAR_LOWER_A = 8'h61;
  localparam byte_t CHAR_LOWER_Z = 8'h7a;
  localparam byte_t CHAR_UPPER_A = 8'h41;
  localparam byte_t CHAR_UPPER_Z = 8'h5a;
  localparam byte_t CHAR_SPACE   = 8'h20;

  localparam index_t LAST_INDEX = INDEX_WIDTH'(NUM_LETTERS - 1);
  localparam count_t COUNT_MAX  = '1;

endpackage

>>> rtl/frk_in_if.sv
// ----------------------------------------------------------------------------
// frk_in_if
// Text request channel: action code and raw text byte.
// ----------------------------------------------------------------------------
interface frk_in_if;
  logic            valid;
  logic            ready;
  logic [1:0]      action;
  frk_pkg::byte_t  letter;

  modport source (output valid, output action, output letter, input ready);
  modport sink   (input valid, input action, input letter, output ready);
endinterface

>>> rtl/frk_out_if.sv
// ----------------------------------------------------------------------------
// frk_out_if
// Key request channel: one substitution key entry per request.
// ----------------------------------------------------------------------------
interface frk_out_if;
  logic            valid;
  logic            ready;
  frk_pkg::index_t cipher_index;
  frk_pkg::byte_t  key_char;
  logic            last;

  modport source (output valid, output cipher_index, output key_char, output last,
                  input ready);
  modport sink   (input valid, input cipher_index, input key_char, input last,
                  output ready);
endinterface

>>> rtl/frequency_rank_key_builder.sv
// ----------------------------------------------------------------------------
// frequency_rank_key_builder
// Counts reference and ciphertext letters, then ranks both histograms and
// emits a 26-entry starter substitution key.
// ----------------------------------------------------------------------------
//
//   channel | role | payload                           | handshake
//   --------+------+-----------------------------------+------------
//   text    | in   | action, letter                    | valid/ready
//   key     | out  | cipher_index, key_char, last      | valid/ready
//
// Each letter request (reference or ciphertext) updates its histogram; text.ready
// stays high while the block is idle, so letters stream back to back.
// A finish request runs a shared scan/compare unit: each ranking pass reads
// one histogram entry per cycle, with one pass per distinct count plus a
// closing pass for each histogram. Then 26 key requests leave through the
// output register, one per cycle when key.ready is high; a stall on key
// holds the emitter. text.ready is low from the finish request until the
// last key entry is loaded.
// Reset (rst, synchronous) clears both histograms and the sequencer.
// ----------------------------------------------------------------------------
module frequency_rank_key_builder (
  input  logic      clk,
  input  logic      rst,
  frk_in_if.sink    text,
  frk_out_if.source key
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state;

  // Histograms: one shared read address, chosen by the phase.
  frk_pkg::count_t ref_cnt [frk_pkg::NUM_LETTERS];
  frk_pkg::count_t ct_cnt  [frk_pkg::NUM_LETTERS];

  // Ranked reference letters and the key under construction.
  frk_pkg::index_t ref_order  [frk_pkg::NUM_LETTERS];
  frk_pkg::index_t key_letter [frk_pkg::NUM_LETTERS];
  logic [frk_pkg::NUM_LETTERS-1:0] key_known;

  // Scan unit state.
  logic            hist_sel;     // 0 reference, 1 ciphertext
  frk_pkg::index_t scan_idx;
  frk_pkg::index_t rank_n;
  frk_pkg::index_t nref;
  frk_pkg::count_t prev;
  logic            have_prev;
  logic            found;
  frk_pkg::count_t best;
  frk_pkg::index_t best_letter;

  frk_pkg::index_t emit_idx;

  // Output register.
  logic            out_valid;
  frk_pkg::index_t out_index;
  frk_pkg::byte_t  out_char;
  logic            out_last;

  // Letter decode for counting.
  frk_pkg::byte_t  folded;
  logic            cnt_hit;
  frk_pkg::index_t cnt_idx;
  logic            accept;

  frk_pkg::index_t rd_addr;
  frk_pkg::count_t rd_ref;
  frk_pkg::count_t rd_ct;
  frk_pkg::count_t rd_cnt;

  logic            take;
  logic            found_fin;
  frk_pkg::count_t best_fin;
  frk_pkg::index_t letter_fin;
  frk_pkg::byte_t  emit_char;

  assign accept     = text.valid && text.ready;
  assign text.ready = (state == ST_IDLE);

  // Fold upper case only for ciphertext, then keep lower-case letters.
  always_comb begin
    folded = text.letter;
    if (text.action == frk_pkg::ACT_CIPHER &&
        text.letter >= frk_pkg::CHAR_UPPER_A && text.letter <= frk_pkg::CHAR_UPPER_Z) begin
      folded = text.letter - frk_pkg::CHAR_UPPER_A + frk_pkg::CHAR_LOWER_A;
    end
    cnt_hit = (folded >= frk_pkg::CHAR_LOWER_A) && (folded <= frk_pkg::CHAR_LOWER_Z);
    cnt_idx = frk_pkg::INDEX_WIDTH'(folded - frk_pkg::CHAR_LOWER_A);
  end

  // Single read port per histogram.
  assign rd_addr = (state == ST_IDLE) ? cnt_idx : scan_idx;
  assign rd_ref  = ref_cnt[rd_addr];
  assign rd_ct   = ct_cnt[rd_addr];
  assign rd_cnt  = hist_sel ? rd_ct : rd_ref;

  // Shared compare unit: keep the highest letter with the largest count
  // strictly below the previous rank's count.
  always_comb begin
    take       = (!have_prev || rd_cnt < prev) && (!found || rd_cnt >= best);
    found_fin  = found || take;
    best_fin   = take ? rd_cnt : best;
    letter_fin = take ? scan_idx : best_letter;
  end

  assign emit_char = key_known[emit_idx]
                   ? frk_pkg::CHAR_LOWER_A + {3'b000, key_letter[emit_idx]}
                   : frk_pkg::CHAR_SPACE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hist_sel  <= 1'b0;
      scan_idx  <= '0;
      rank_n    <= '0;
      nref      <= '0;
      have_prev <= 1'b0;
      found     <= 1'b0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
      key_known <= '0;
      for (int i = 0; i < frk_pkg::NUM_LETTERS; i++) begin
        ref_cnt[i] <= '0;
        ct_cnt[i]  <= '0;
      end
    end else begin
      // Drop the output request once taken; EMIT drives it on its own.
      if (out_valid && key.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (text.action)
              frk_pkg::ACT_REFERENCE: begin
                if (cnt_hit && rd_ref != frk_pkg::COUNT_MAX) begin
                  ref_cnt[cnt_idx] <= rd_ref + 1'b1;
                end
              end
              frk_pkg::ACT_CIPHER: begin
                if (cnt_hit && rd_ct != frk_pkg::COUNT_MAX) begin
                  ct_cnt[cnt_idx] <= rd_ct + 1'b1;
                end
              end
              frk_pkg::ACT_FINISH: begin
                state     <= ST_SCAN;
                hist_sel  <= 1'b0;
                scan_idx  <= '0;
                rank_n    <= '0;
                have_prev <= 1'b0;
                found     <= 1'b0;
                key_known <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (scan_idx == frk_pkg::LAST_INDEX) begin
            // End of pass: record a representative or close this histogram.
            scan_idx <= '0;
            found    <= 1'b0;
            if (found_fin) begin
              if (!hist_sel) begin
                ref_order[rank_n] <= letter_fin;
              end else if (rank_n < nref) begin
                key_letter[letter_fin] <= ref_order[rank_n];
                key_known[letter_fin]  <= 1'b1;
              end
              rank_n    <= rank_n + 1'b1;
              prev      <= best_fin;
              have_prev <= 1'b1;
            end else if (!hist_sel) begin
              nref      <= rank_n;
              rank_n    <= '0;
              have_prev <= 1'b0;
              hist_sel  <= 1'b1;
            end else begin
              state    <= ST_EMIT;
              emit_idx <= '0;
              for (int i = 0; i < frk_pkg::NUM_LETTERS; i++) begin
                ref_cnt[i] <= '0;
                ct_cnt[i]  <= '0;
              end
            end
          end else begin
            scan_idx    <= scan_idx + 1'b1;
            found       <= found_fin;
            best        <= best_fin;
            best_letter <= letter_fin;
          end
        end

        ST_EMIT: begin
          // Advance only when the output register is free or being taken.
          if (!out_valid || key.ready) begin
            out_valid <= 1'b1;
            out_index <= emit_idx;
            out_char  <= emit_char;
            out_last  <= (emit_idx == frk_pkg::LAST_INDEX);
            if (emit_idx == frk_pkg::LAST_INDEX) begin
              emit_idx <= '0;
              state    <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign key.valid        = out_valid;
  assign key.cipher_index = out_index;
  assign key.key_char     = out_char;
  assign key.last         = out_last;

endmodule

>>> bench/frequency_rank_key_builder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_rank_key_builder_test
// Self-checking bench for the frequency rank key builder. Feeds reference and
// ciphertext bytes plus finish requests, predicts the 26-entry key for each
// finish, and compares every key request leaving the block in order.
// ----------------------------------------------------------------------------
module frequency_rank_key_builder_test;

  typedef struct packed {
    frk_pkg::action_t action;
    frk_pkg::byte_t   letter;
  } text_req_t;

  typedef struct packed {
    frk_pkg::index_t cipher_index;
    frk_pkg::byte_t  key_char;
    logic            last;
  } key_entry_t;

  logic clk;
  logic rst;

  frk_in_if  text ();
  frk_out_if key ();

  frequency_rank_key_builder i_dut (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .key  (key)
  );

  // Stimulus backlog, filled by the sequencer below and drained by the driver.
  text_req_t  text_backlog[$];
  // Key entries predicted for finish requests, oldest first.
  key_entry_t pending_key_entries[$];

  // Predictor copy of the two letter histograms.
  frk_pkg::count_t reference_hist[frk_pkg::NUM_LETTERS];
  frk_pkg::count_t cipher_hist[frk_pkg::NUM_LETTERS];

  int mismatch_count   = 0;
  int counted_requests = 0;
  int send_idle_pct    = 0;
  int recv_idle_pct    = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic frk_pkg::count_t saturating_inc(input frk_pkg::count_t c);
    return (c == frk_pkg::COUNT_MAX) ? c : frk_pkg::count_t'(c + 1'b1);
  endfunction

  // Fill order[] with one letter per distinct count, highest count first.
  // Among letters sharing a count only the highest letter stands; zero counts
  // take part like any other. Return how many ranks were found.
  function automatic int rank_by_count(input frk_pkg::count_t hist[frk_pkg::NUM_LETTERS],
                                       output frk_pkg::index_t order[frk_pkg::NUM_LETTERS]);
    int              n;
    logic            have_ceiling;
    logic            found;
    frk_pkg::count_t ceiling;
    frk_pkg::count_t best;
    int              best_letter;
    n            = 0;
    have_ceiling = 1'b0;
    ceiling      = '0;
    for (int k = 0; k < frk_pkg::NUM_LETTERS; k++) order[k] = '0;
    while (n < frk_pkg::NUM_LETTERS) begin
      found       = 1'b0;
      best        = '0;
      best_letter = 0;
      for (int i = 0; i < frk_pkg::NUM_LETTERS; i++) begin
        if (!(have_ceiling && hist[i] >= ceiling) && (!found || hist[i] >= best)) begin
          found       = 1'b1;
          best        = hist[i];
          best_letter = i;
        end
      end
      if (!found) break;
      order[n]     = frk_pkg::index_t'(best_letter);
      n++;
      ceiling      = best;
      have_ceiling = 1'b1;
    end
    return n;
  endfunction

  // Pair cipher and reference ranks, queue the 26 key entries, clear counts.
  task automatic predict_key();
    frk_pkg::index_t reference_order[frk_pkg::NUM_LETTERS];
    frk_pkg::index_t cipher_order[frk_pkg::NUM_LETTERS];
    frk_pkg::byte_t  guess[frk_pkg::NUM_LETTERS];
    int              n_reference;
    int              n_cipher;
    key_entry_t      entry;
    n_reference = rank_by_count(reference_hist, reference_order);
    n_cipher    = rank_by_count(cipher_hist, cipher_order);
    for (int k = 0; k < frk_pkg::NUM_LETTERS; k++) guess[k] = frk_pkg::CHAR_SPACE;
    for (int r = 0; r < n_cipher; r++) begin
      guess[cipher_order[r]] = (r < n_reference) ?
          frk_pkg::byte_t'(frk_pkg::CHAR_LOWER_A + reference_order[r]) : frk_pkg::CHAR_SPACE;
    end
    for (int k = 0; k < frk_pkg::NUM_LETTERS; k++) begin
      entry.cipher_index  = frk_pkg::index_t'(k);
      entry.key_char      = guess[k];
      entry.last          = (k == frk_pkg::NUM_LETTERS - 1);
      pending_key_entries = {pending_key_entries, entry};
    end
    reference_hist = '{default: '0};
    cipher_hist    = '{default: '0};
  endtask

  // Advance the predictor by one accepted text request.
  task automatic apply_text_request(input frk_pkg::action_t act, input frk_pkg::byte_t b);
    frk_pkg::byte_t  folded;
    frk_pkg::index_t slot;
    case (act)
      frk_pkg::ACT_REFERENCE: begin
        if (b >= frk_pkg::CHAR_LOWER_A && b <= frk_pkg::CHAR_LOWER_Z) begin
          slot                 = frk_pkg::index_t'(b - frk_pkg::CHAR_LOWER_A);
          reference_hist[slot] = saturating_inc(reference_hist[slot]);
        end
      end
      frk_pkg::ACT_CIPHER: begin
        folded = (b >= frk_pkg::CHAR_UPPER_A && b <= frk_pkg::CHAR_UPPER_Z) ?
                 frk_pkg::byte_t'(b - frk_pkg::CHAR_UPPER_A + frk_pkg::CHAR_LOWER_A) : b;
        if (folded >= frk_pkg::CHAR_LOWER_A && folded <= frk_pkg::CHAR_LOWER_Z) begin
          slot              = frk_pkg::index_t'(folded - frk_pkg::CHAR_LOWER_A);
          cipher_hist[slot] = saturating_inc(cipher_hist[slot]);
        end
      end
      frk_pkg::ACT_FINISH: predict_key();
      default: ;  // unused code: no effect at all
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_key_entry(input frk_pkg::index_t idx, input frk_pkg::byte_t ch,
                                 input logic last);
    key_entry_t want;
    if (pending_key_entries.size() == 0) begin
      flag_mismatch($sformatf("unexpected key entry index %0d char %h last %b",
                              idx, ch, last));
    end else begin
      want = pending_key_entries.pop_front();
      if (idx != want.cipher_index)
        flag_mismatch($sformatf("cipher_index %0d, want %0d", idx, want.cipher_index));
      if (ch != want.key_char)
        flag_mismatch($sformatf("key_char %h at index %0d, want %h",
                                ch, want.cipher_index, want.key_char));
      if (last != want.last)
        flag_mismatch($sformatf("last %b at index %0d, want %b",
                                last, want.cipher_index, want.last));
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and limit
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Timeout guard: end a run that hangs.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: present the next backlog request whenever the channel is free.
  // Sample ready at the edge, so the previous request is accepted here when
  // valid and ready were both high; feed it to the predictor first.
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : text_driver
    text_req_t next_req;
    if (rst) begin
      text.valid  <= 1'b0;
      text.action <= frk_pkg::ACT_REFERENCE;
      text.letter <= '0;
    end else begin
      if (text.valid && text.ready)
        apply_text_request(frk_pkg::action_t'(text.action), text.letter);
      if (!text.valid || text.ready) begin
        if (text_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req     = text_backlog.pop_front();
          text.valid  <= 1'b1;
          text.action <= next_req.action;
          text.letter <= next_req.letter;
        end else begin
          text.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted key request, then pick the next ready level.
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : key_monitor
    if (rst) begin
      key.ready <= 1'b0;
    end else begin
      if (key.valid && key.ready)
        check_key_entry(key.cipher_index, key.key_char, key.last);
      key.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Queue one request; only those that can change state count toward totals.
  task automatic queue_request(input frk_pkg::action_t act, input frk_pkg::byte_t b,
                               input logic counted);
    text_req_t req;
    req.action   = act;
    req.letter   = b;
    text_backlog = {text_backlog, req};
    if (counted) counted_requests++;
  endtask

  // One passage: a skewed mix of reference and ciphertext letters with some
  // noise, usually closed by a finish. Skew toward low letters so counts
  // spread out and tie in varied ways. An unfinished passage carries its
  // counts into the next one.
  task automatic queue_passage();
    int n_letters;
    int ref_span;
    int cipher_span;
    int pick;
    int idx;
    frk_pkg::byte_t ch;
    n_letters   = $urandom_range(4, 40);
    ref_span    = $urandom_range(0, 25);
    cipher_span = $urandom_range(0, 25);
    for (int k = 0; k < n_letters; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        queue_request(frk_pkg::action_t'($urandom_range(3)),
                      frk_pkg::byte_t'($urandom_range(255)), 1'b0);
      end else if (pick < 54) begin
        idx = $urandom_range(0, $urandom_range(0, ref_span));
        queue_request(frk_pkg::ACT_REFERENCE, frk_pkg::byte_t'(frk_pkg::CHAR_LOWER_A + idx),
                      1'b1);
      end else begin
        idx = $urandom_range(0, $urandom_range(0, cipher_span));
        ch  = $urandom_range(1) ? frk_pkg::byte_t'(frk_pkg::CHAR_UPPER_A + idx)
                                : frk_pkg::byte_t'(frk_pkg::CHAR_LOWER_A + idx);
        queue_request(frk_pkg::ACT_CIPHER, ch, 1'b1);
      end
    end
    if ($urandom_range(99) < 85)
      queue_request(frk_pkg::ACT_FINISH, frk_pkg::byte_t'($urandom_range(255)), 1'b1);
  endtask

  // Hold until the backlog is sent and every predicted key entry has arrived.
  // Poll on the falling edge, clear of the driver and monitor updates.
  task automatic wait_for_quiet();
    while (text_backlog.size() != 0 || text.valid || pending_key_entries.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    rst            = 1'b1;
    reference_hist = '{default: '0};
    cipher_hist    = '{default: '0};

    // Sender idles often, receiver idles most of the time.
    send_idle_pct = 31;
    recv_idle_pct = 71;

    // Finish on empty histograms: every count is zero, so only z ranks, z -> z.
    queue_request(frk_pkg::ACT_FINISH, 8'hff, 1'b1);

    // Reference: both ends of the alphabet; drop nonletters, upper case and
    // the byte just above z.
    queue_request(frk_pkg::ACT_REFERENCE, frk_pkg::CHAR_LOWER_A, 1'b1);
    queue_request(frk_pkg::ACT_REFERENCE, frk_pkg::CHAR_LOWER_Z, 1'b1);
    queue_request(frk_pkg::ACT_REFERENCE, frk_pkg::CHAR_LOWER_Z, 1'b1);
    queue_request(frk_pkg::ACT_REFERENCE, 8'h00, 1'b0);
    queue_request(frk_pkg::ACT_REFERENCE, 8'hff, 1'b0);
    queue_request(frk_pkg::ACT_REFERENCE, frk_pkg::CHAR_UPPER_A, 1'b0);
    queue_request(frk_pkg::ACT_REFERENCE, frk_pkg::byte_t'(frk_pkg::CHAR_LOWER_Z + 1), 1'b0);

    // Ciphertext: fold upper case, drop both neighbors of A..Z, the byte below a and 8'h80.
    queue_request(frk_pkg::ACT_CIPHER, frk_pkg::CHAR_UPPER_A, 1'b1);
    queue_request(frk_pkg::ACT_CIPHER, frk_pkg::CHAR_LOWER_A, 1'b1);
    queue_request(frk_pkg::ACT_CIPHER, frk_pkg::CHAR_UPPER_Z, 1'b1);
    queue_request(frk_pkg::ACT_CIPHER, frk_pkg::byte_t'(frk_pkg::CHAR_UPPER_A - 1), 1'b0);
    queue_request(frk_pkg::ACT_CIPHER, frk_pkg::byte_t'(frk_pkg::CHAR_UPPER_Z + 1), 1'b0);
    queue_request(frk_pkg::ACT_CIPHER, frk_pkg::byte_t'(frk_pkg::CHAR_LOWER_A - 1), 1'b0);
    queue_request(frk_pkg::ACT_CIPHER, 8'h80, 1'b0);

    // Unused action code is ignored entirely.
    queue_request(frk_pkg::ACT_UNUSED, frk_pkg::byte_t'(frk_pkg::CHAR_LOWER_A + 16), 1'b0);
    queue_request(frk_pkg::ACT_FINISH, 8'h00, 1'b1);

    // Reference only: cipher stays all zero, so z takes the top reference rank.
    queue_request(frk_pkg::ACT_REFERENCE, frk_pkg::byte_t'(frk_pkg::CHAR_LOWER_A + 12), 1'b1);
    queue_request(frk_pkg::ACT_FINISH, 8'h55, 1'b1);

    // Cipher ranks outnumber reference ranks: the surplus maps to a space.
    queue_request(frk_pkg::ACT_CIPHER, frk_pkg::byte_t'(frk_pkg::CHAR_LOWER_A + 2), 1'b1);
    queue_request(frk_pkg::ACT_CIPHER, frk_pkg::byte_t'(frk_pkg::CHAR_UPPER_A + 2), 1'b1);
    queue_request(frk_pkg::ACT_CIPHER, frk_pkg::byte_t'(frk_pkg::CHAR_LOWER_A + 1), 1'b1);
    queue_request(frk_pkg::ACT_FINISH, 8'haa, 1'b1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Pause the sender until the directed keys are all back.
    wait_for_quiet();

    counted_requests = 0;
    while (counted_requests < 50) queue_passage();
    wait_for_quiet();

    // Swap: sender idles most, receiver only sometimes.
    send_idle_pct    = 71;
    recv_idle_pct    = 31;
    counted_requests = 0;
    while (counted_requests < 50) queue_passage();
    wait_for_quiet();

    // No idling on either side.
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    counted_requests = 0;
    while (counted_requests < 50) queue_passage();
    // Close any open passage so its counts get checked too.
    queue_request(frk_pkg::ACT_FINISH, 8'h3c, 1'b1);
    wait_for_quiet();

    // Catch stray key requests after the last expected one.
    repeat (100) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
